// ----- rtl/pppd_pkg.sv -----
`default_nettype none
package pppd_pkg;

   localparam int BUFFER_DEPTH = 32;
   localparam int TAG_BITS     = 16;

   localparam int DEST_W   = 32;
   localparam int TAG_IO_W = 16;
   localparam int TAG_WIDE = (TAG_BITS > TAG_IO_W) ? TAG_BITS : TAG_IO_W;
   localparam int IDX_W    = $clog2(BUFFER_DEPTH);
   localparam int CNT_W    = $clog2(BUFFER_DEPTH + 1);

   // request codes
   localparam logic REQ_PARK    = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_PARKED   = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_RELEASED = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic [DEST_W-1:0]   dest;
      logic [TAG_BITS-1:0] tag;
      logic                kind;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/pending_packet_park_and_drain.sv -----
// Park: result beat in the cycle after the request; one park per cycle while results go.
// Release over N stored entries: one buffer read per cycle while no held match waits on a
//   stalled result beat; S_WALK examines the entries, then S_FLUSH sends the closing beat
//   and the sequencer returns to S_IDLE, where the next request can be taken.
// Reset (synchronous, active high) empties the buffer and drops any pending result beat;
//   buffer contents are left as they are; only entries below the entry count are used.
`default_nettype none
module pending_packet_park_and_drain
   import pppd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_type,
   input  wire logic [DEST_W-1:0]   req_dest_addr,
   input  wire logic [TAG_IO_W-1:0] req_frame_tag,
   input  wire logic                req_frame_kind,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [TAG_IO_W-1:0]      rsp_out_tag,
   output logic                     rsp_out_kind,
   output logic [DEST_W-1:0]        rsp_out_dest,
   output logic                     rsp_last
);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;   // waiting for a request beat
   localparam logic [1:0] S_WALK  = 2'd1;   // one entry examined per cycle unless stalled
   localparam logic [1:0] S_FLUSH = 2'd2;   // closing result of a release

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;       // number of valid entries
   logic [CNT_W-1:0]  rd_ff, rd_in;         // walk read position
   logic [CNT_W-1:0]  wr_ff, wr_in;         // compaction write position
   logic [DEST_W-1:0] key_ff, key_in;       // release destination
   entry_type         hold_ff, hold_in;     // last match found, not yet sent
   logic              hold_vld_ff, hold_vld_in;

   // buffer memory, one write and one registered read per cycle
   entry_type         mem [BUFFER_DEPTH];
   entry_type         rdata_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;
   logic              rd_load;
   logic [IDX_W-1:0]  rd_addr;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [TAG_IO_W-1:0] tag_ff, tag_in;
   logic                kind_ff, kind_in;
   logic [DEST_W-1:0]   dest_ff, dest_in;
   logic                last_ff, last_in;
   logic                out_load;
   logic                out_free;

   logic                req_fire;
   logic [CNT_W-1:0]    rd_next;
   logic                match;
   logic                step;
   logic [TAG_WIDE-1:0] tag_wide_in;
   logic [TAG_WIDE-1:0] tag_wide_out;
   entry_type           park_entry;

   // the output register can take a beat when empty or when its beat leaves now
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   // parked tag keeps its low TAG_BITS bits; result tag gives the low 16 of that
   assign tag_wide_in     = TAG_WIDE'(req_frame_tag);
   assign tag_wide_out    = TAG_WIDE'(hold_ff.tag);
   assign park_entry.dest = req_dest_addr;
   assign park_entry.tag  = tag_wide_in[TAG_BITS-1:0];
   assign park_entry.kind = req_frame_kind;

   assign rd_next = rd_ff + CNT_W'(1);
   assign match   = (rdata_ff.dest == key_ff);
   // a second match may only displace the held one once that can go out
   assign step    = (state_ff == S_WALK) && (!match || !hold_vld_ff || out_free);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      key_in      = key_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_ff[IDX_W-1:0];
      mem_wdata   = rdata_ff;
      rd_load     = 1'b0;
      rd_addr     = rd_next[IDX_W-1:0];
      out_load    = 1'b0;
      status_in   = ST_NONE;
      tag_in      = '0;
      kind_in     = 1'b0;
      dest_in     = '0;
      last_in     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_fire) begin
               if (req_type == REQ_PARK) begin
                  out_load = 1'b1;
                  if (cnt_ff == CNT_W'(BUFFER_DEPTH)) begin
                     // full: drop, state untouched
                     status_in = ST_DROPPED;
                  end else begin
                     status_in = ST_PARKED;
                     mem_we    = 1'b1;
                     mem_waddr = cnt_ff[IDX_W-1:0];
                     mem_wdata = park_entry;
                     cnt_in    = cnt_ff + CNT_W'(1);
                  end
               end else begin
                  key_in      = req_dest_addr;
                  rd_in       = '0;
                  wr_in       = '0;
                  hold_vld_in = 1'b0;
                  rd_load     = 1'b1;
                  state_in    = (cnt_ff == '0) ? S_FLUSH : S_WALK;
               end
            end
         end

         S_WALK: begin
            if (step) begin
               if (match) begin
                  if (hold_vld_ff) begin
                     out_load  = 1'b1;
                     status_in = ST_RELEASED;
                     tag_in    = tag_wide_out[TAG_IO_W-1:0];
                     kind_in   = hold_ff.kind;
                     dest_in   = hold_ff.dest;
                     last_in   = 1'b0;
                  end
                  hold_in     = rdata_ff;
                  hold_vld_in = 1'b1;
               end else begin
                  // keep entry, move it down over released ones
                  mem_we = 1'b1;
                  wr_in  = wr_ff + CNT_W'(1);
               end
               rd_in   = rd_next;
               rd_load = 1'b1;
               if (rd_next == cnt_ff) begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (hold_vld_ff) begin
                  status_in = ST_RELEASED;
                  tag_in    = tag_wide_out[TAG_IO_W-1:0];
                  kind_in   = hold_ff.kind;
                  dest_in   = hold_ff.dest;
               end else begin
                  status_in = ST_NONE;
               end
               cnt_in      = wr_ff;
               hold_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_load) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
      if (out_load) begin
         status_ff <= status_in;
         tag_ff    <= tag_in;
         kind_ff   <= kind_in;
         dest_ff   <= dest_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_out_tag  = tag_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_dest = dest_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ----- rtl/pppd_checker.sv -----
`default_nettype none
module pppd_checker
   import pppd_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_type,
   input wire logic [DEST_W-1:0]   req_dest_addr,
   input wire logic [TAG_IO_W-1:0] req_frame_tag,
   input wire logic                req_frame_kind,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [1:0]          rsp_status,
   input wire logic [TAG_IO_W-1:0] rsp_out_tag,
   input wire logic                rsp_out_kind,
   input wire logic [DEST_W-1:0]   rsp_out_dest,
   input wire logic                rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag)
         && $stable(rsp_out_kind) && $stable(rsp_out_dest) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // park answers on the next cycle with a single closing beat
   a_park_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_PARK) |=> rsp_valid && rsp_last
         && ((rsp_status == ST_PARKED) || (rsp_status == ST_DROPPED)))
      else $error("park without its result beat");

   // a release keeps the request side closed while it walks
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_RELEASE) |=> req_stall)
      else $error("request taken during release walk");

   // only released beats carry entry fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_RELEASED) |-> (rsp_out_tag == '0)
         && !rsp_out_kind && (rsp_out_dest == '0) && rsp_last)
      else $error("non-release beat with entry fields or open");

endmodule

bind pending_packet_park_and_drain pppd_checker u_pppd_checker (.*);
`default_nettype wire

// ----- tb/sv/pending_packet_park_and_drain_tb.sv -----
`default_nettype none
module pending_packet_park_and_drain_tb;
   import pppd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Stop the stimulus queue growing once it holds this many request beats.
   localparam int TOTAL_REQS  = 455;
   // Generous: ~500 requests, releases walking up to BUFFER_DEPTH entries, plus stalls.
   localparam int CYCLE_LIMIT = 400000;
   // Long receiver hold-offs, armed once the accepted count passes each mark.
   localparam int HOLD_LEN    = 150;
   localparam int HOLD_MARK_A = 100;
   localparam int HOLD_MARK_B = 360;
   // Idle phases, counted in accepted request beats.
   localparam int PHASE_A_END = 160;
   localparam int PHASE_B_END = 320;

   // One request beat as it waits in the stimulus queue.
   typedef struct {
      logic                op;
      logic [DEST_W-1:0]   dest;
      logic [TAG_IO_W-1:0] tag;
      logic                kind;
      bit                  drain_first;   // sender waits for every result first
   } park_req_type;

   // One result beat as the buffer should produce it.
   typedef struct {
      logic [1:0]          status;
      logic [TAG_IO_W-1:0] tag;
      logic                kind;
      logic [DEST_W-1:0]   dest;
      logic                last;
   } drain_beat_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic                req_type       = REQ_PARK;
   logic [DEST_W-1:0]   req_dest_addr  = '0;
   logic [TAG_IO_W-1:0] req_frame_tag  = '0;
   logic                req_frame_kind = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [1:0]          rsp_status;
   logic [TAG_IO_W-1:0] rsp_out_tag;
   logic                rsp_out_kind;
   logic [DEST_W-1:0]   rsp_out_dest;
   logic                rsp_last;

   park_req_type   pending_reqs[$];    // filled by the stimulus block, drained by the driver
   drain_beat_type due_beats[$];       // results still owed by the buffer, oldest first
   entry_type      parked_frames[$];   // predicted buffer contents, oldest first
   logic [DEST_W-1:0] gen_dests[$];    // stimulus-side view of parked dests, for aiming keys

   bit offering       = 1'b0;       // driver currently holds a beat on the request port
   bit hold_next      = 1'b0;
   int beats_accepted = 0;
   int cycle_count    = 0;
   int mismatches     = 0;
   int hold_left      = 0;
   int hold_idx       = 0;

   pending_packet_park_and_drain u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_dest_addr  (req_dest_addr),
      .req_frame_tag  (req_frame_tag),
      .req_frame_kind (req_frame_kind),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_dest   (rsp_out_dest),
      .rsp_last       (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic void owe_beat(logic [1:0] status, logic [TAG_IO_W-1:0] tag,
                                    logic kind, logic [DEST_W-1:0] dest, logic last);
      drain_beat_type b;
      b.status = status;
      b.tag    = tag;
      b.kind   = kind;
      b.dest   = dest;
      b.last   = last;
      due_beats.push_back(b);
   endfunction

   // Applies one accepted request to the predicted buffer and queues its results.
   function automatic void predict_buffer_step(park_req_type r);
      entry_type e;
      entry_type kept[$];
      int        hits;
      hits = 0;
      if (r.op == REQ_PARK) begin
         if (parked_frames.size() >= BUFFER_DEPTH) begin
            // full: request is thrown away, buffer untouched
            owe_beat(ST_DROPPED, '0, 1'b0, '0, 1'b1);
         end else begin
            e.dest = r.dest;
            e.tag  = TAG_BITS'(r.tag);
            e.kind = r.kind;
            parked_frames.push_back(e);
            owe_beat(ST_PARKED, '0, 1'b0, '0, 1'b1);
         end
      end else begin
         // walk oldest to newest; matches go out, the rest close up in order
         foreach (parked_frames[i]) begin
            if (parked_frames[i].dest == r.dest) begin
               owe_beat(ST_RELEASED, TAG_IO_W'(parked_frames[i].tag), parked_frames[i].kind,
                        parked_frames[i].dest, 1'b0);
               hits++;
            end else begin
               kept.push_back(parked_frames[i]);
            end
         end
         parked_frames = kept;
         if (hits == 0)
            owe_beat(ST_NONE, '0, 1'b0, '0, 1'b1);
         else
            due_beats[due_beats.size()-1].last = 1'b1;
      end
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Idle schedule: sender light / receiver heavy, then swapped, then none
   // ------------------------------------------------------------------

   function automatic int sender_idle_pct();
      if (beats_accepted < PHASE_A_END) return 9;
      if (beats_accepted < PHASE_B_END) return 46;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (beats_accepted < PHASE_A_END) return 46;
      if (beats_accepted < PHASE_B_END) return 9;
      return 0;
   endfunction

   // ------------------------------------------------------------------
   // Driver: request port, changes on the falling edge
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!offering) begin
         // a held beat stays put; a new one is only picked once the last was taken
         if (pending_reqs.size() != 0
             && !(pending_reqs[0].drain_first && due_beats.size() != 0)
             && $urandom_range(99) >= sender_idle_pct()) begin
            req_valid      <= 1'b1;
            req_type       <= pending_reqs[0].op;
            req_dest_addr  <= pending_reqs[0].dest;
            req_frame_tag  <= pending_reqs[0].tag;
            req_frame_kind <= pending_reqs[0].kind;
            offering = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall: random back-pressure plus the long hold-offs
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if ((hold_idx == 0 && beats_accepted >= HOLD_MARK_A)
                   || (hold_idx == 1 && beats_accepted >= HOLD_MARK_B)) begin
         // sender keeps offering meanwhile, so the buffer backs up into req_stall
         rsp_stall <= 1'b1;
         hold_left = HOLD_LEN - 1;
         hold_idx++;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   // ------------------------------------------------------------------
   // Monitor: both handshakes sampled on the rising edge
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      drain_beat_type want;
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_beats.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing owed: status %0d tag %h",
                                       rsp_status, rsp_out_tag));
            end else begin
               want = due_beats.pop_front();
               if (rsp_status !== want.status)
                  note_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_out_tag !== want.tag)
                  note_mismatch($sformatf("out_tag %h, want %h", rsp_out_tag, want.tag));
               if (rsp_out_kind !== want.kind)
                  note_mismatch($sformatf("out_kind %b, want %b", rsp_out_kind, want.kind));
               if (rsp_out_dest !== want.dest)
                  note_mismatch($sformatf("out_dest %h, want %h", rsp_out_dest, want.dest));
               if (rsp_last !== want.last)
                  note_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         // a result never comes out on the edge that takes its request
         if (req_valid && !req_stall) begin
            predict_buffer_step(pending_reqs.pop_front());
            offering = 1'b0;
            beats_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic void add_req(logic op, logic [DEST_W-1:0] dest,
                                   logic [TAG_IO_W-1:0] tag, logic kind);
      park_req_type r;
      logic [DEST_W-1:0] left[$];
      r.op          = op;
      r.dest        = dest;
      r.tag         = tag;
      r.kind        = kind;
      r.drain_first = hold_next;
      hold_next     = 1'b0;
      pending_reqs.push_back(r);
      // keep a rough idea of what is parked so release keys can be aimed
      if (op == REQ_PARK) begin
         if (gen_dests.size() < BUFFER_DEPTH) gen_dests.push_back(dest);
      end else begin
         foreach (gen_dests[i]) if (gen_dests[i] != dest) left.push_back(gen_dests[i]);
         gen_dests = left;
      end
   endfunction

   function automatic logic [DEST_W-1:0] pick_key(logic [DEST_W-1:0] pool[4]);
      if (gen_dests.size() != 0 && $urandom_range(3) == 0)
         return gen_dests[$urandom_range(gen_dests.size() - 1)];
      return pool[$urandom_range(3)];
   endfunction

   initial begin
      logic [DEST_W-1:0] pool[4];
      int  pick;
      bit  first_fill;
      first_fill = 1'b1;

      // --- directed ---
      add_req(REQ_RELEASE, 32'h0000_0000, 16'h0000, 1'b0);   // empty buffer: none matched
      add_req(REQ_PARK,    32'h0000_0000, 16'h0000, 1'b0);
      add_req(REQ_PARK,    32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      add_req(REQ_PARK,    32'h0000_0000, 16'h5555, 1'b1);
      add_req(REQ_PARK,    32'h1234_5678, 16'hAAAA, 1'b0);
      add_req(REQ_PARK,    32'hFFFF_FFFF, 16'h0001, 1'b0);
      add_req(REQ_RELEASE, 32'h0000_0000, 16'hFFFF, 1'b1);   // two out, the rest close up
      add_req(REQ_RELEASE, 32'h0000_0000, 16'h0000, 1'b0);   // already gone
      add_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'h0000, 1'b0);   // first and last entries
      add_req(REQ_RELEASE, 32'h1234_5678, 16'h0000, 1'b0);   // empties the buffer
      add_req(REQ_RELEASE, 32'hFFFF_FFFF, 16'h1234, 1'b1);
      hold_next = 1'b1;                                      // pause before the random part

      // --- random episodes ---
      while (pending_reqs.size() < TOTAL_REQS) begin
         pick = $urandom_range(99);
         foreach (pool[i]) begin
            case ($urandom_range(15))
               0:       pool[i] = '0;
               1:       pool[i] = '1;
               default: pool[i] = $urandom;
            endcase
         end
         if (!hold_next) hold_next = ($urandom_range(15) == 0);
         if (first_fill || pick < 15) begin
            // fill to the brim, overflow a little, then drain by key
            first_fill = 1'b0;
            while (gen_dests.size() < BUFFER_DEPTH)
               add_req(REQ_PARK, pool[$urandom_range(3)], TAG_IO_W'($urandom),
                       1'($urandom_range(1)));
            repeat ($urandom_range(1, 3))
               add_req(REQ_PARK, $urandom, TAG_IO_W'($urandom), 1'($urandom_range(1)));
            foreach (pool[i])
               add_req(REQ_RELEASE, pool[i], TAG_IO_W'($urandom), 1'($urandom_range(1)));
         end else if (pick < 75) begin
            // parks onto a few shared keys, then releases aimed mostly at them
            repeat ($urandom_range(2, 12))
               add_req(REQ_PARK, pool[$urandom_range(3)], TAG_IO_W'($urandom),
                       1'($urandom_range(1)));
            repeat ($urandom_range(1, 4))
               add_req(REQ_RELEASE, pick_key(pool), TAG_IO_W'($urandom),
                       1'($urandom_range(1)));
         end else begin
            // noise: anything goes
            repeat ($urandom_range(1, 6))
               add_req(1'($urandom_range(1)), $urandom, TAG_IO_W'($urandom),
                       1'($urandom_range(1)));
         end
      end
   end

   // Reset release and end of run live here; stimulus above is built at time 0.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || offering || due_beats.size() != 0)
         @(posedge clock);
      // a release sends its closing beat only once its walk is over; this wait is spare
      repeat (BUFFER_DEPTH + 10) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/pppd_pkg.sv
rtl/pending_packet_park_and_drain.sv
rtl/pppd_checker.sv
tb/sv/pending_packet_park_and_drain_tb.sv
